[rtl/pbd_pkg.sv]
package pbd_pkg;

  // Channel and sum widths
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned SUM_W    = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned FACTOR_W   = 5;
  localparam int unsigned AREA_W     = 2 * FACTOR_W;

  localparam int unsigned HEIGHT_LIMIT = 4096;

  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd480;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd2;

  localparam logic COLOR_MONO = 1'b0;
  localparam logic COLOR_RGB  = 1'b1;

  // Reciprocal of the block area: floor(2^RECIP_SHIFT / area)
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned DIVIDEND_W  = RECIP_W;
  localparam int unsigned DIV_CNT_W   = 5;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BIN_FACTOR   = 2'd2,
    REG_COLOR_MODE   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    G_W_GO,
    G_W_WAIT,
    G_H_GO,
    G_H_WAIT,
    G_R_GO,
    G_R_WAIT,
    G_LIMIT,
    G_READY
  } geo_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ACC,
    B_MUL,
    B_FIX
  } back_state_e;

  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0] pix;
    logic                         fresh;
    logic                         block_end;
    logic                         eor;
    logic                         eof;
  } item_t;

  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [RECIP_W-1:0] recip;
    logic               color_mode;
  } setup_t;

endpackage

[rtl/pixel_bin_downsampler.sv]
// A block's last pixel goes through the queue, then the back's read, add-and-write,
//   multiply and fix states before its result stands valid in the output register.
// Throughput: the front takes one pixel a cycle, kept or dropped, into a 4-entry queue
//   unless the queue is full or the geometry pass runs; the back takes one kept pixel at a
//   time (line store read, then add and write, and on a block's last pixel also multiply
//   and fix), and a stalled result held in the output register holds the back in fix.
// Reset (async, active low) clears the counters and loads the register defaults; after
//   reset and after any register write the input stalls until the geometry pass is done.
module pixel_bin_downsampler #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_BIN   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Pixel requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pbd_pkg::PIX_W-1:0]         red_i,
  input  logic [pbd_pkg::PIX_W-1:0]         green_i,
  input  logic [pbd_pkg::PIX_W-1:0]         blue_i,
  // Binned pixel requests
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pbd_pkg::PIX_W-1:0]         avg_red_o,
  output logic [pbd_pkg::PIX_W-1:0]         avg_green_o,
  output logic [pbd_pkg::PIX_W-1:0]         avg_blue_o,
  output logic                              end_of_row_o,
  output logic                              end_of_frame_o,
  // Register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned DATA_W = $bits(pbd_pkg::item_t) + ADDR_W;

  logic [pbd_pkg::NUM_CH-1:0][pbd_pkg::PIX_W-1:0] pix_in, avg;

  logic              push, pop, full, empty;
  pbd_pkg::item_t    push_item, pop_item;
  logic [ADDR_W-1:0] push_addr, pop_addr;
  logic [DATA_W-1:0] pop_data;
  pbd_pkg::setup_t   setup;

  // Registers take every write at once; the front restarts its geometry pass
  assign cfg_ready_o = 1'b1;

  // Channel 0 is red
  assign pix_in = {blue_i, green_i, red_i};

  // Front: hold the raster position, classify each pixel, drop those past the
  // last whole block, and derive output size and area reciprocal from the registers
  pbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BIN   (MAX_BIN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pix_i       (pix_in),
    .push_o      (push),
    .push_item_o (push_item),
    .push_addr_o (push_addr),
    .full_i      (full),
    .setup_o     (setup)
  );

  // Queue of kept pixels with their line store column
  pbd_fifo #(
    .DATA_W (DATA_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_item, push_addr}),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  assign pop_item = pbd_pkg::item_t'(pop_data[DATA_W-1:ADDR_W]);
  assign pop_addr = pop_data[ADDR_W-1:0];

  // Back: accumulate column sums, divide by the area on a block's last pixel,
  // and hold the result in the output register until taken
  pbd_back #(
    .DEPTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .item_i      (pop_item),
    .addr_i      (pop_addr),
    .setup_i     (setup),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .avg_o       (avg),
    .eor_o       (end_of_row_o),
    .eof_o       (end_of_frame_o)
  );

  assign avg_red_o   = avg[0];
  assign avg_green_o = avg[1];
  assign avg_blue_o  = avg[2];

endmodule

[rtl/pbd_div.sv]
module pbd_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pbd_pkg::DIVIDEND_W-1:0]      dividend_i,
  input  logic [pbd_pkg::AREA_W-1:0]          divisor_i,
  output logic                                done_o,
  output logic [pbd_pkg::DIVIDEND_W-1:0]      quotient_o
);

  logic [pbd_pkg::AREA_W-1:0]     rem_q;
  logic [pbd_pkg::DIVIDEND_W-1:0] quo_q;
  logic [pbd_pkg::AREA_W-1:0]     den_q;
  logic [pbd_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [pbd_pkg::AREA_W:0]       trial;
  logic                           fits;

  // One quotient bit a cycle, restoring
  assign trial = {rem_q, quo_q[pbd_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= pbd_pkg::DIV_CNT_W'(pbd_pkg::DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != pbd_pkg::DIV_CNT_W'(1);
      done_q <= cnt_q == pbd_pkg::DIV_CNT_W'(1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? pbd_pkg::AREA_W'(trial - {1'b0, den_q})
                    : trial[pbd_pkg::AREA_W-1:0];
      quo_q <= {quo_q[pbd_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/pbd_front.sv]
module pbd_front #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_BIN   = 16,
  localparam int unsigned ADDR_W   = $clog2(MAX_WIDTH)
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_valid_i,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]                   cfg_index_i,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]                  cfg_data_i,
  input  logic                                            in_valid_i,
  output logic                                            in_stall_o,
  input  logic [pbd_pkg::NUM_CH-1:0][pbd_pkg::PIX_W-1:0]  pix_i,
  output logic                                            push_o,
  output pbd_pkg::item_t                                  push_item_o,
  output logic [ADDR_W-1:0]                               push_addr_o,
  input  logic                                            full_i,
  output pbd_pkg::setup_t                                 setup_o
);

  localparam int unsigned OC_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WMAX = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int unsigned FMAX = (MAX_BIN < 31) ? MAX_BIN : 31;

  logic [pbd_pkg::DIM_W-1:0]    cfg_w_q, cfg_h_q;
  logic [pbd_pkg::FACTOR_W-1:0] cfg_f_q;
  logic                         cfg_mode_q;

  logic [pbd_pkg::DIM_W-1:0]    w_eff, h_eff;
  logic [pbd_pkg::FACTOR_W-1:0] f_eff;
  logic [pbd_pkg::AREA_W-1:0]   area_c;

  pbd_pkg::geo_state_e state_q, state_d;

  logic                             div_start, div_done;
  logic [pbd_pkg::DIVIDEND_W-1:0]   div_dividend, div_quotient;
  logic [pbd_pkg::AREA_W-1:0]       div_divisor;

  logic [pbd_pkg::DIM_W-1:0]    out_w_q, out_h_q, row_limit_q;
  logic [pbd_pkg::AREA_W-1:0]   area_q;
  logic [pbd_pkg::RECIP_W-1:0]  recip_q;

  logic [pbd_pkg::DIM_W-1:0]    pc_q;
  logic [pbd_pkg::ROW_W-1:0]    pr_q;
  logic [pbd_pkg::FACTOR_W-1:0] cib_q, rib_q;
  logic [OC_W-1:0]              oc_q;

  logic accept, row_end, frame_end, in_range, last_col;
  logic [pbd_pkg::DIM_W-1:0]    w_m1, h_m1, pr_ext;
  logic [pbd_pkg::FACTOR_W-1:0] f_m1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= pbd_pkg::WIDTH_RST;
      cfg_h_q    <= pbd_pkg::HEIGHT_RST;
      cfg_f_q    <= pbd_pkg::FACTOR_RST;
      cfg_mode_q <= pbd_pkg::COLOR_RGB;
    end else if (cfg_valid_i) begin
      unique case (pbd_pkg::cfg_reg_e'(cfg_index_i))
        pbd_pkg::REG_IMAGE_WIDTH:  cfg_w_q    <= cfg_data_i[pbd_pkg::DIM_W-1:0];
        pbd_pkg::REG_IMAGE_HEIGHT: cfg_h_q    <= cfg_data_i[pbd_pkg::DIM_W-1:0];
        pbd_pkg::REG_BIN_FACTOR:   cfg_f_q    <= cfg_data_i[pbd_pkg::FACTOR_W-1:0];
        pbd_pkg::REG_COLOR_MODE:   cfg_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their working range
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = pbd_pkg::DIM_W'(1);
    end else if (int'(cfg_w_q) > int'(WMAX)) begin
      w_eff = pbd_pkg::DIM_W'(WMAX);
    end else begin
      w_eff = cfg_w_q;
    end
    if (cfg_h_q == '0) begin
      h_eff = pbd_pkg::DIM_W'(1);
    end else if (int'(cfg_h_q) > int'(pbd_pkg::HEIGHT_LIMIT)) begin
      h_eff = pbd_pkg::DIM_W'(pbd_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = cfg_h_q;
    end
    if (cfg_f_q == '0) begin
      f_eff = pbd_pkg::FACTOR_W'(1);
    end else if (int'(cfg_f_q) > int'(FMAX)) begin
      f_eff = pbd_pkg::FACTOR_W'(FMAX);
    end else begin
      f_eff = cfg_f_q;
    end
  end

  assign area_c = {{pbd_pkg::FACTOR_W{1'b0}}, f_eff} * {{pbd_pkg::FACTOR_W{1'b0}}, f_eff};

  pbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // Geometry sequencer: output width, output height, area reciprocal, row limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbd_pkg::G_W_GO;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = pbd_pkg::DIVIDEND_W'(w_eff);
    div_divisor  = pbd_pkg::AREA_W'(f_eff);
    unique case (state_q)
      pbd_pkg::G_W_GO: begin
        div_start = 1'b1;
        state_d   = pbd_pkg::G_W_WAIT;
      end
      pbd_pkg::G_W_WAIT: begin
        if (div_done) state_d = pbd_pkg::G_H_GO;
      end
      pbd_pkg::G_H_GO: begin
        div_start    = 1'b1;
        div_dividend = pbd_pkg::DIVIDEND_W'(h_eff);
        state_d      = pbd_pkg::G_H_WAIT;
      end
      pbd_pkg::G_H_WAIT: begin
        if (div_done) state_d = pbd_pkg::G_R_GO;
      end
      pbd_pkg::G_R_GO: begin
        div_start    = 1'b1;
        div_dividend = pbd_pkg::DIVIDEND_W'(1) << pbd_pkg::RECIP_SHIFT;
        div_divisor  = area_c;
        state_d      = pbd_pkg::G_R_WAIT;
      end
      pbd_pkg::G_R_WAIT: begin
        if (div_done) state_d = pbd_pkg::G_LIMIT;
      end
      pbd_pkg::G_LIMIT: state_d = pbd_pkg::G_READY;
      pbd_pkg::G_READY: ;
      default: state_d = pbd_pkg::G_W_GO;
    endcase
    // Any register write restarts the derivation
    if (cfg_valid_i) state_d = pbd_pkg::G_W_GO;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pbd_pkg::G_W_WAIT && div_done) begin
      out_w_q <= div_quotient[pbd_pkg::DIM_W-1:0];
    end
    if (state_q == pbd_pkg::G_H_WAIT && div_done) begin
      out_h_q <= div_quotient[pbd_pkg::DIM_W-1:0];
    end
    if (state_q == pbd_pkg::G_R_GO) begin
      area_q <= area_c;
    end
    if (state_q == pbd_pkg::G_R_WAIT && div_done) begin
      recip_q <= div_quotient;
    end
    if (state_q == pbd_pkg::G_LIMIT) begin
      row_limit_q <= pbd_pkg::DIM_W'(out_h_q * f_eff);
    end
  end

  // Classify the pixel at the current raster position
  assign in_stall_o = (state_q != pbd_pkg::G_READY) || full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign w_m1   = w_eff - 1'b1;
  assign h_m1   = h_eff - 1'b1;
  assign f_m1   = f_eff - 1'b1;
  assign pr_ext = pbd_pkg::DIM_W'(pr_q);

  assign row_end   = pc_q >= w_m1;
  assign frame_end = row_end && (pr_ext >= h_m1);
  assign in_range  = (int'(oc_q) < int'(out_w_q)) && (int'(oc_q) < int'(MAX_WIDTH)) &&
                     (pr_ext < row_limit_q);
  assign last_col  = int'(oc_q) == int'(out_w_q) - 1;

  always_comb begin
    push_item_o.pix       = pix_i;
    push_item_o.fresh     = (rib_q == '0) && (cib_q == '0);
    push_item_o.block_end = (rib_q >= f_m1) && (cib_q >= f_m1);
    push_item_o.eor       = last_col;
    push_item_o.eof       = last_col && (pr_ext >= row_limit_q - pbd_pkg::DIM_W'(f_eff));
  end

  assign push_o      = accept && in_range;
  assign push_addr_o = oc_q[ADDR_W-1:0];

  // Raster and block counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      pr_q  <= '0;
      cib_q <= '0;
      rib_q <= '0;
      oc_q  <= '0;
    end else if (accept) begin
      if (row_end) begin
        pc_q  <= '0;
        cib_q <= '0;
        oc_q  <= '0;
        if (frame_end) begin
          pr_q  <= '0;
          rib_q <= '0;
        end else begin
          pr_q  <= pr_q + 1'b1;
          rib_q <= (rib_q >= f_m1) ? '0 : rib_q + 1'b1;
        end
      end else begin
        pc_q <= pc_q + 1'b1;
        if (cib_q >= f_m1) begin
          cib_q <= '0;
          if (int'(oc_q) < int'(MAX_WIDTH)) oc_q <= oc_q + 1'b1;
        end else begin
          cib_q <= cib_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    setup_o.area       = area_q;
    setup_o.recip      = recip_q;
    setup_o.color_mode = cfg_mode_q;
  end

endmodule

[rtl/pbd_fifo.sv]
module pbd_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              full_o,
  output logic              empty_o
);

  logic [DATA_W-1:0]          slot_q [pbd_pkg::QUEUE_DEPTH];
  logic [pbd_pkg::QPTR_W-1:0] wp_q, rp_q;
  logic [pbd_pkg::QCNT_W-1:0] cnt_q;
  logic                       do_push, do_pop;

  assign full_o  = cnt_q == pbd_pkg::QCNT_W'(pbd_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wp_q] <= push_data_i;
  end

  assign pop_data_o = slot_q[rp_q];

endmodule

[rtl/pbd_back.sv]
module pbd_back #(
  parameter int unsigned DEPTH  = 4096,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            empty_i,
  output logic                                            pop_o,
  input  pbd_pkg::item_t                                  item_i,
  input  logic [ADDR_W-1:0]                               addr_i,
  input  pbd_pkg::setup_t                                 setup_i,
  output logic                                            out_valid_o,
  input  logic                                            out_stall_i,
  output logic [pbd_pkg::NUM_CH-1:0][pbd_pkg::PIX_W-1:0]  avg_o,
  output logic                                            eor_o,
  output logic                                            eof_o
);

  localparam int unsigned LINE_W = pbd_pkg::NUM_CH * pbd_pkg::SUM_W;
  localparam int unsigned PROD_W = pbd_pkg::SUM_W + pbd_pkg::RECIP_W;
  localparam int unsigned CHK_W  = pbd_pkg::SUM_W + pbd_pkg::AREA_W;

  logic [LINE_W-1:0] line_mem [DEPTH];

  pbd_pkg::back_state_e state_q, state_d;

  pbd_pkg::item_t                                cur_q;
  logic [ADDR_W-1:0]                             addr_q;
  logic [LINE_W-1:0]                             rd_q;
  logic [pbd_pkg::NUM_CH-1:0][pbd_pkg::SUM_W-1:0] sum_q, sum_c;
  logic [pbd_pkg::NUM_CH-1:0][pbd_pkg::SUM_W-1:0] quo_q;
  logic [pbd_pkg::NUM_CH-1:0][pbd_pkg::PIX_W-1:0] avg_c, avg_q;
  logic [pbd_pkg::NUM_CH-1:0][PROD_W-1:0]         prod_c;
  logic [pbd_pkg::NUM_CH-1:0][CHK_W-1:0]          rem_c;
  logic                                          out_valid_q, eor_q, eof_q;
  logic                                          rd_en, wr_en, load_out;

  // Add the pixel to the column's partial sum
  always_comb begin
    for (int c = 0; c < pbd_pkg::NUM_CH; c++) begin
      sum_c[c] = (cur_q.fresh ? '0 : rd_q[c*pbd_pkg::SUM_W +: pbd_pkg::SUM_W]) +
                 pbd_pkg::SUM_W'(cur_q.pix[c]);
    end
  end

  // Quotient estimate by reciprocal, then at most one correction step
  always_comb begin
    for (int c = 0; c < pbd_pkg::NUM_CH; c++) begin
      prod_c[c] = PROD_W'(sum_q[c]) * PROD_W'(setup_i.recip);
      rem_c[c]  = CHK_W'(sum_q[c]) - CHK_W'(quo_q[c]) * CHK_W'(setup_i.area);
      avg_c[c]  = pbd_pkg::PIX_W'(quo_q[c] +
                  pbd_pkg::SUM_W'(rem_c[c] >= CHK_W'(setup_i.area)));
    end
    if (setup_i.color_mode == pbd_pkg::COLOR_MONO) begin
      for (int c = 1; c < pbd_pkg::NUM_CH; c++) begin
        avg_c[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbd_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      pbd_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          rd_en   = 1'b1;
          state_d = pbd_pkg::B_ACC;
        end
      end
      pbd_pkg::B_ACC: begin
        wr_en   = 1'b1;
        state_d = cur_q.block_end ? pbd_pkg::B_MUL : pbd_pkg::B_IDLE;
      end
      pbd_pkg::B_MUL: state_d = pbd_pkg::B_FIX;
      pbd_pkg::B_FIX: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = pbd_pkg::B_IDLE;
        end
      end
      default: state_d = pbd_pkg::B_IDLE;
    endcase
  end

  // Line store: one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= line_mem[addr_i];
    if (wr_en) line_mem[addr_q] <= sum_c;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= item_i;
      addr_q <= addr_i;
    end
    if (wr_en) sum_q <= sum_c;
    if (state_q == pbd_pkg::B_MUL) begin
      for (int c = 0; c < pbd_pkg::NUM_CH; c++) begin
        quo_q[c] <= prod_c[c][pbd_pkg::RECIP_SHIFT +: pbd_pkg::SUM_W];
      end
    end
    if (load_out) begin
      avg_q <= avg_c;
      eor_q <= cur_q.eor;
      eof_q <= cur_q.eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg_o       = avg_q;
  assign eor_o       = eor_q;
  assign eof_o       = eof_q;

endmodule

[sim/pbd_checker.sv]
module pbd_checker
  import pbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_BIN   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [PIX_W-1:0]      red_i,
  input  logic [PIX_W-1:0]      green_i,
  input  logic [PIX_W-1:0]      blue_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [PIX_W-1:0]      avg_red_i,
  input  logic [PIX_W-1:0]      avg_green_i,
  input  logic [PIX_W-1:0]      avg_blue_i,
  input  logic                  end_of_row_i,
  input  logic                  end_of_frame_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           binned_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             eor;
    logic             eof;
  } binned_px_t;

  // Register copy
  logic [DIM_W-1:0]    width_q;
  logic [DIM_W-1:0]    height_q;
  logic [FACTOR_W-1:0] factor_q;
  logic                mode_q;

  // Line store and raster position
  logic [SUM_W-1:0] column_sum [MAX_WIDTH][NUM_CH];
  int unsigned      px_col;
  int unsigned      px_row;
  int unsigned      col_in_blk;
  int unsigned      row_in_blk;
  int unsigned      out_col;

  binned_px_t binned_q [$];
  binned_px_t oldest;

  function automatic int unsigned bounded(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    $display("pbd_checker: %0t ns %s got %0d, want %0d", $time, field, got, want);
    mismatch_count_o++;
  endtask

  // Accumulate one pixel into its column sum; queue a binned pixel when a block closes.
  task automatic bin_pixel(input logic [PIX_W-1:0] r, g, b);
    int unsigned      w;
    int unsigned      h;
    int unsigned      f;
    int unsigned      out_w;
    int unsigned      out_h;
    int unsigned      area;
    int unsigned      c;
    logic [PIX_W-1:0] px [NUM_CH];
    logic [SUM_W-1:0] base;
    logic             row_end;
    logic             frame_end;
    logic             fresh;
    binned_px_t       res;
    w     = bounded(width_q, 1, MAX_WIDTH);
    h     = bounded(height_q, 1, HEIGHT_LIMIT);
    f     = bounded(factor_q, 1, MAX_BIN);
    out_w = w / f;
    out_h = h / f;
    area  = f * f;
    px[0] = r;
    px[1] = g;
    px[2] = b;
    row_end   = (px_col >= w - 1);
    frame_end = row_end && (px_row >= h - 1);

    if (out_col < out_w && px_row < out_h * f) begin
      fresh = (row_in_blk == 0) && (col_in_blk == 0);
      for (c = 0; c < NUM_CH; c++) begin
        base = fresh ? '0 : column_sum[out_col][c];
        column_sum[out_col][c] = base + px[c];
      end
      if (row_in_blk >= f - 1 && col_in_blk >= f - 1) begin
        res.red   = PIX_W'(column_sum[out_col][0] / area);
        res.green = PIX_W'(column_sum[out_col][1] / area);
        res.blue  = PIX_W'(column_sum[out_col][2] / area);
        if (mode_q == COLOR_MONO) begin
          res.green = '0;
          res.blue  = '0;
        end
        res.eor = (out_col == out_w - 1);
        res.eof = res.eor && (px_row / f == out_h - 1);
        binned_q.push_back(res);
      end
    end

    if (row_end) begin
      px_col     = 0;
      col_in_blk = 0;
      out_col    = 0;
      if (frame_end) begin
        px_row     = 0;
        row_in_blk = 0;
      end else begin
        px_row++;
        row_in_blk = (row_in_blk >= f - 1) ? 0 : row_in_blk + 1;
      end
    end else begin
      px_col++;
      if (col_in_blk >= f - 1) begin
        col_in_blk = 0;
        if (out_col < MAX_WIDTH) out_col++;
      end else begin
        col_in_blk++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q          = WIDTH_RST;
      height_q         = HEIGHT_RST;
      factor_q         = FACTOR_RST;
      mode_q           = COLOR_RGB;
      px_col           = 0;
      px_row           = 0;
      col_in_blk       = 0;
      row_in_blk       = 0;
      out_col          = 0;
      mismatch_count_o = 0;
      binned_q.delete();
      binned_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_IMAGE_WIDTH:  width_q  = cfg_data_i[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_q = cfg_data_i[DIM_W-1:0];
          REG_BIN_FACTOR:   factor_q = cfg_data_i[FACTOR_W-1:0];
          REG_COLOR_MODE:   mode_q   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) bin_pixel(red_i, green_i, blue_i);
      if (out_valid_i && !out_stall_i) begin
        if (binned_q.size() == 0) begin
          report("binned pixel with none pending", 1, 0);
        end else begin
          oldest = binned_q.pop_front();
          if (avg_red_i !== oldest.red)        report("avg_red", avg_red_i, oldest.red);
          if (avg_green_i !== oldest.green)    report("avg_green", avg_green_i, oldest.green);
          if (avg_blue_i !== oldest.blue)      report("avg_blue", avg_blue_i, oldest.blue);
          if (end_of_row_i !== oldest.eor)     report("end_of_row", end_of_row_i, oldest.eor);
          if (end_of_frame_i !== oldest.eof)   report("end_of_frame", end_of_frame_i, oldest.eof);
        end
      end
      binned_pending_o <= binned_q.size();
    end
  end

endmodule

[sim/tb_pixel_bin_downsampler.sv]
module tb_pixel_bin_downsampler;
  timeunit 1ns;
  timeprecision 1ps;

  import pbd_pkg::*;

  localparam int unsigned LINE_MAX      = 4096;
  localparam int unsigned BIN_MAX       = 16;
  localparam int unsigned RANDOM_PIXELS = 320;
  // Queue of four pixels plus the back's pipeline: ample margin
  localparam int unsigned DRAIN_CYCLES  = 40;
  // Longest legal quiet spell is a drain plus the geometry pass after a write
  localparam int unsigned IDLE_LIMIT    = 2000;

  typedef enum int unsigned {
    PAT_RANDOM,
    PAT_FULL,
    PAT_ZERO,
    PAT_TINY
  } sample_pat_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Pixel requests into the block
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] red      = '0;
  logic [PIX_W-1:0] green    = '0;
  logic [PIX_W-1:0] blue     = '0;

  // Binned pixel requests out of the block
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] avg_red;
  logic [PIX_W-1:0] avg_green;
  logic [PIX_W-1:0] avg_blue;
  logic             end_of_row;
  logic             end_of_frame;

  // Register writes
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned mismatches;
  int unsigned binned_pending;

  // Stimulus side view of the registers and of the row position, so that
  // register writes land only on a block-row boundary
  int unsigned cur_w      = WIDTH_RST;
  int unsigned cur_h      = HEIGHT_RST;
  int unsigned cur_f      = FACTOR_RST;
  int unsigned row_pos    = 0;
  int unsigned row_in_blk = 0;

  int unsigned pixels_sent = 0;
  int unsigned random_goal;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold;
  int unsigned stall_left  = 0;
  int unsigned f_pick;
  sample_pat_e pat;
  // Quiet stretches: neither side idles
  logic        quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  pixel_bin_downsampler #(
    .MAX_WIDTH(LINE_MAX),
    .MAX_BIN  (BIN_MAX)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .avg_red_o     (avg_red),
    .avg_green_o   (avg_green),
    .avg_blue_o    (avg_blue),
    .end_of_row_o  (end_of_row),
    .end_of_frame_o(end_of_frame),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  pbd_checker #(
    .MAX_WIDTH(LINE_MAX),
    .MAX_BIN  (BIN_MAX)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .avg_red_i       (avg_red),
    .avg_green_i     (avg_green),
    .avg_blue_i      (avg_blue),
    .end_of_row_i    (end_of_row),
    .end_of_frame_i  (end_of_frame),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatches),
    .binned_pending_o(binned_pending)
  );

  // Receiver: after each accepted result, stall or not at random; never in quiet stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      rx_hold     = quiet ? 0 : $urandom_range(0, 3);
      stall_left <= rx_hold;
      out_stall  <= (rx_hold != 0);
    end
  end

  // Watchdog: count cycles in which no request of any kind is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Effective size of a register value: zero acts as one, large values saturate.
  function automatic int unsigned capped(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [PIX_W-1:0] pick_level(input sample_pat_e p);
    case (p)
      PAT_FULL: return '1;
      PAT_ZERO: return '0;
      PAT_TINY: return PIX_W'($urandom_range(0, 1));
      default:  return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel request after a random gap; hold it until accepted.
  task automatic push_pixel(input logic [PIX_W-1:0] r, g, b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk_i); while (in_stall);
    pixels_sent++;
  endtask

  // Send n pixels of the current row; the row position stays where it is.
  task automatic send_pixels(input int unsigned n, input sample_pat_e p);
    repeat (n) push_pixel(pick_level(p), pick_level(p), pick_level(p));
  endtask

  // Send one whole input row and advance the row position as the block does.
  task automatic send_row(input sample_pat_e p);
    int unsigned w;
    int unsigned h;
    int unsigned f;
    int unsigned col;
    w = capped(cur_w, LINE_MAX);
    h = capped(cur_h, HEIGHT_LIMIT);
    f = capped(cur_f, BIN_MAX);
    for (col = 0; col < w; col++) push_pixel(pick_level(p), pick_level(p), pick_level(p));
    if (row_pos >= h - 1) begin
      row_pos    = 0;
      row_in_blk = 0;
    end else begin
      row_pos++;
      row_in_blk = (row_in_blk >= f - 1) ? 0 : row_in_blk + 1;
    end
  endtask

  // Send n rows, then carry on to the next block-row boundary.
  task automatic run_rows(input int unsigned n, input sample_pat_e p);
    repeat (n) send_row(p);
    while (row_in_blk != 0) send_row(p);
  endtask

  // Finish the current frame, then n-1 further whole frames.
  task automatic run_frames(input int unsigned n, input sample_pat_e p);
    repeat (n) begin
      do send_row(p); while (row_pos != 0);
    end
  endtask

  // Drop valid, wait until every binned pixel is back, then let the queue drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (binned_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write request; the leading edge keeps valid from dropping and
  // rising in the same step across back-to-back writes.
  task automatic set_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  cur_w = data[DIM_W-1:0];
      REG_IMAGE_HEIGHT: cur_h = data[DIM_W-1:0];
      REG_BIN_FACTOR:   cur_f = data[FACTOR_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of height, factor and mode: two rows at width four, all
    // samples at full scale, give two binned pixels with no frame end.
    settle();
    set_reg(REG_IMAGE_WIDTH, 4);
    run_rows(2, PAT_FULL);

    // Shrink the height below the current row: the frame ends at once and
    // the row is dropped.
    settle();
    set_reg(REG_IMAGE_HEIGHT, 2);
    run_frames(1, PAT_RANDOM);

    // Single pixel image, factor one, mono: green and blue read zero.
    settle();
    set_reg(REG_BIN_FACTOR, 1);
    set_reg(REG_IMAGE_WIDTH, 1);
    set_reg(REG_IMAGE_HEIGHT, 1);
    set_reg(REG_COLOR_MODE, COLOR_MONO);
    run_frames(1, PAT_FULL);

    // Zero sizes and zero factor act as one.
    settle();
    set_reg(REG_BIN_FACTOR, 0);
    set_reg(REG_IMAGE_WIDTH, 0);
    set_reg(REG_IMAGE_HEIGHT, 0);
    set_reg(REG_COLOR_MODE, COLOR_RGB);
    run_frames(1, PAT_RANDOM);

    // Factor larger than the image: everything dropped.
    settle();
    set_reg(REG_BIN_FACTOR, 3);
    set_reg(REG_IMAGE_WIDTH, 2);
    set_reg(REG_IMAGE_HEIGHT, 2);
    run_frames(1, PAT_RANDOM);

    // Odd sizes drop the last column and row; tiny samples test truncation.
    settle();
    set_reg(REG_BIN_FACTOR, 2);
    set_reg(REG_IMAGE_WIDTH, 3);
    set_reg(REG_IMAGE_HEIGHT, 3);
    run_frames(1, PAT_TINY);

    // Random phases: small images, mostly small factors, now and then a zero
    // or saturating factor; some phases stop on a block-row boundary inside a
    // frame so that the next writes land mid-frame.
    random_goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < random_goal) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0)
        set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
      if ($urandom_range(0, 2) != 0)
        set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 9)));
      if ($urandom_range(0, 2) != 0) begin
        f_pick = $urandom_range(0, 9);
        set_reg(REG_BIN_FACTOR, CFG_DATA_W'((f_pick == 0) ? 0 :
                                (f_pick == 1) ? $urandom_range(17, 31) : $urandom_range(1, 4)));
      end
      if ($urandom_range(0, 3) == 0)
        set_reg(REG_COLOR_MODE, ($urandom_range(0, 1) != 0) ? COLOR_RGB : COLOR_MONO);
      pat = ($urandom_range(0, 7) == 0) ? sample_pat_e'($urandom_range(1, 3)) : PAT_RANDOM;
      if ($urandom_range(0, 2) == 0) run_rows($urandom_range(1, 3), pat);
      else run_frames($urandom_range(1, 2), pat);
    end
    // Close any open frame so the large phases start on row zero
    run_frames(1, PAT_RANDOM);

    // Largest factor (saturated) over a full-scale 16 by 16 image: peak sums.
    settle();
    quiet = 1'b0;
    set_reg(REG_BIN_FACTOR, 31);
    set_reg(REG_IMAGE_WIDTH, 16);
    set_reg(REG_IMAGE_HEIGHT, 16);
    set_reg(REG_COLOR_MODE, COLOR_RGB);
    run_frames(1, PAT_FULL);

    // Saturated width and height at factor one: the opening pixels of a
    // line-store-wide row, each its own block.
    settle();
    set_reg(REG_BIN_FACTOR, 1);
    set_reg(REG_IMAGE_WIDTH, 8191);
    set_reg(REG_IMAGE_HEIGHT, 8191);
    set_reg(REG_COLOR_MODE, COLOR_MONO);
    send_pixels(16, PAT_RANDOM);

    // Cut width and height under the current position: row and frame end on
    // the next pixel, which is dropped.
    settle();
    set_reg(REG_IMAGE_WIDTH, 4);
    set_reg(REG_IMAGE_HEIGHT, 1);
    run_frames(1, PAT_RANDOM);

    settle();
    if (mismatches == 0 && binned_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
